[rtl/core/wsws_pkg.sv]
// Package for the white-space word splitter.
// Holds mode and item-kind codes, byte constants and the shared item and state types.
// No dependencies.
package wsws_pkg;

    localparam int ModeWidth = 3;
    localparam int CharWidth = 8;
    localparam int KindWidth = 2;

    localparam logic [ModeWidth-1:0] MODE_NORMAL   = 3'd0;
    localparam logic [ModeWidth-1:0] MODE_NOWRAP   = 3'd1;
    localparam logic [ModeWidth-1:0] MODE_PRE      = 3'd2;
    localparam logic [ModeWidth-1:0] MODE_PRE_LINE = 3'd3;
    localparam logic [ModeWidth-1:0] MODE_PRE_WRAP = 3'd4;

    localparam logic [KindWidth-1:0] KIND_CHAR  = 2'd0;
    localparam logic [KindWidth-1:0] KIND_SPACE = 2'd1;
    localparam logic [KindWidth-1:0] KIND_BREAK = 2'd2;

    localparam logic [CharWidth-1:0] BYTE_NUL     = 8'd0;
    localparam logic [CharWidth-1:0] BYTE_TAB     = 8'd9;
    localparam logic [CharWidth-1:0] BYTE_NEWLINE = 8'd10;
    localparam logic [CharWidth-1:0] BYTE_CR      = 8'd13;
    localparam logic [CharWidth-1:0] BYTE_SPACE   = 8'd32;

    typedef struct packed {
        logic [CharWidth-1:0] out_char;
        logic [KindWidth-1:0] item_kind;
        logic                 starts_word;
        logic                 line_break;
        logic                 last_of_run;
    } item_t;

    typedef struct packed {
        logic [1:0] count;
        item_t      first;
        item_t      second;
    } result_t;

    typedef struct packed {
        logic at_text_start;
        logic prev_was_space;
        logic prev_was_newline;
        logic pending_space;
    } split_state_t;

    localparam split_state_t STATE_RESET = '{
        at_text_start:    1'b1,
        prev_was_space:   1'b0,
        prev_was_newline: 1'b0,
        pending_space:    1'b0
    };

    function automatic item_t make_item(input logic [CharWidth-1:0] ch,
                                        input logic [KindWidth-1:0] kind,
                                        input logic start, input logic brk);
        item_t it;
        it.out_char    = ch;
        it.item_kind   = kind;
        it.starts_word = start;
        it.line_break  = brk;
        it.last_of_run = 1'b0;
        return it;
    endfunction

endpackage

[rtl/core/wsws_classify.sv]
// Combinational classifier for one text byte under the current white-space mode.
// Produces up to two result items and the next splitter state; uses wsws_pkg.
module wsws_classify (
    input  logic [wsws_pkg::ModeWidth-1:0] mode,
    input  logic [wsws_pkg::CharWidth-1:0] in_char,
    input  logic                           end_of_text,
    input  wsws_pkg::split_state_t         cur_state,
    output wsws_pkg::result_t              result,
    output wsws_pkg::split_state_t         next_state
);
    import wsws_pkg::*;

    logic  is_ws;
    logic  is_nl;
    logic  pending;
    item_t space_item;
    item_t break_item;
    item_t char_item;

    assign is_ws = (in_char == BYTE_SPACE) || ((in_char >= BYTE_TAB) && (in_char <= BYTE_CR));
    assign is_nl = (in_char == BYTE_NEWLINE);
    assign space_item = make_item(BYTE_SPACE, KIND_SPACE, 1'b1, 1'b0);
    assign break_item = make_item(BYTE_NUL, KIND_BREAK, 1'b1, 1'b1);

    always_comb begin
        result.count  = 2'd0;
        result.first  = space_item;
        result.second = space_item;
        char_item     = make_item(in_char, KIND_CHAR,
                                  cur_state.at_text_start || cur_state.prev_was_space, 1'b0);
        pending       = 1'b0;
        unique case (mode)
            MODE_PRE: begin
                result.count = 2'd1;
                result.first = make_item(in_char, KIND_CHAR,
                                         cur_state.at_text_start || cur_state.prev_was_newline,
                                         is_nl);
            end
            MODE_PRE_LINE: begin
                if (is_ws && is_nl) begin
                    result.count = 2'd1;
                    result.first = break_item;
                end else if (is_ws) begin
                    pending = !end_of_text;
                    if (end_of_text) begin
                        result.count = 2'd1;
                    end
                end else if (cur_state.pending_space) begin
                    result.count  = 2'd2;
                    result.second = char_item;
                end else begin
                    result.count = 2'd1;
                    result.first = char_item;
                end
            end
            MODE_PRE_WRAP: begin
                result.count = 2'd1;
                result.first = make_item(in_char, KIND_CHAR,
                                         cur_state.at_text_start
                                         || (is_ws != cur_state.prev_was_space), 1'b0);
            end
            default: begin
                if (is_ws) begin
                    if (cur_state.at_text_start || !cur_state.prev_was_space) begin
                        result.count = 2'd1;
                    end
                end else begin
                    result.count = 2'd1;
                    result.first = char_item;
                end
            end
        endcase
        result.first.last_of_run  = (result.count == 2'd1);
        result.second.last_of_run = 1'b1;

        if (end_of_text) begin
            next_state = STATE_RESET;
        end else begin
            next_state.at_text_start    = 1'b0;
            next_state.prev_was_space   = is_ws;
            next_state.prev_was_newline = is_nl;
            next_state.pending_space    = pending;
        end
    end

endmodule

[rtl/core/wsws_out_buf.sv]
// Two-slot result buffer that takes the items of one byte at once and sends them one per beat.
// Drives the result channel; uses wsws_pkg.
module wsws_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  wsws_pkg::result_t load_result,
    input  logic              load_req,
    output logic              load_ok,
    output logic              m_valid,
    input  logic              m_ready,
    output wsws_pkg::item_t   m_item
);
    import wsws_pkg::*;

    item_t      slot0_reg;
    item_t      slot1_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       rd_sel_reg;
    logic       rd_sel_next;
    logic       pop;
    logic       do_load;

    assign m_valid = (count_reg != 2'd0);
    assign m_item  = rd_sel_reg ? slot1_reg : slot0_reg;
    assign pop     = m_valid && m_ready;
    assign load_ok = (load_result.count == 2'd0) || (count_reg == 2'd0)
                     || ((count_reg == 2'd1) && m_ready);
    assign do_load = load_req && load_ok && (load_result.count != 2'd0);

    always_comb begin
        count_next  = count_reg;
        rd_sel_next = rd_sel_reg;
        if (pop) begin
            count_next  = count_reg - 2'd1;
            rd_sel_next = 1'b1;
        end
        if (do_load) begin
            count_next  = load_result.count;
            rd_sel_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            rd_sel_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            rd_sel_reg <= rd_sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_load) begin
            slot0_reg <= load_result.first;
            slot1_reg <= load_result.second;
        end
    end

endmodule

[rtl/core/whitespace_mode_word_splitter_top.sv]
// Top level of the white-space word splitter: input register, mode register and state flags.
// Instantiates wsws_classify and wsws_out_buf; uses wsws_pkg.

// The splitter takes one text byte per beat and gives zero, one or two result items per byte,
// one item per beat, with the word-start, line-break and last-of-run flags on each item.
// A byte is registered on acceptance and classified in the next cycle straight into a
// two-slot result buffer, so bytes that give at most one item flow at one per cycle while
// m_ready is high; a byte that gives two items holds the input while the buffer drains.
// The mode register is written through the cfg channel, which is always ready, and must only
// be written while the splitter is idle.
module whitespace_mode_word_splitter_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wsws_pkg::ModeWidth-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [wsws_pkg::CharWidth-1:0] s_in_char,
    input  logic                           s_end_of_text,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [wsws_pkg::CharWidth-1:0] m_out_char,
    output logic [wsws_pkg::KindWidth-1:0] m_item_kind,
    output logic                           m_starts_word,
    output logic                           m_line_break,
    output logic                           m_last_of_run
);
    import wsws_pkg::*;

    logic [ModeWidth-1:0] mode_reg;
    logic                 in_valid_reg;
    logic [CharWidth-1:0] in_char_reg;
    logic                 in_eot_reg;
    split_state_t         state_reg;
    split_state_t         state_next;
    result_t              result;
    logic                 load_ok;
    logic                 consume;
    item_t                m_item;

    assign cfg_ready = 1'b1;
    assign consume   = in_valid_reg && load_ok;
    assign s_ready   = !in_valid_reg || load_ok;

    wsws_classify u_classify (
        .mode        (mode_reg),
        .in_char     (in_char_reg),
        .end_of_text (in_eot_reg),
        .cur_state   (state_reg),
        .result      (result),
        .next_state  (state_next)
    );

    wsws_out_buf u_out_buf (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load_result (result),
        .load_req    (in_valid_reg),
        .load_ok     (load_ok),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

    assign m_out_char    = m_item.out_char;
    assign m_item_kind   = m_item.item_kind;
    assign m_starts_word = m_item.starts_word;
    assign m_line_break  = m_item.line_break;
    assign m_last_of_run = m_item.last_of_run;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_NORMAL;
            in_valid_reg <= 1'b0;
            state_reg    <= STATE_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (consume) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_in_char;
            in_eot_reg  <= s_end_of_text;
        end
    end

    // Space and break words always open a new word, and a break word always forces a break.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item_kind == KIND_BREAK) |-> m_starts_word && m_line_break
                                                   && (m_out_char == BYTE_NUL))
        else $error("break word with wrong flags");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item_kind == KIND_SPACE) |-> m_starts_word && !m_line_break
                                                   && (m_out_char == BYTE_SPACE))
        else $error("space word with wrong flags");

    // The first item of a pair is followed at once by the second one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_run |=> m_valid)
        else $error("second item of a pair lost");

    // An unsent first item of a pair holds back any byte that gives items.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_run |-> !consume || !in_valid_reg || (result.count == 2'd0))
        else $error("new byte loaded over a pending pair");

endmodule

[tb/sv/wsws_checker.sv]
`timescale 1ns / 1ps
// Checker for the white-space word splitter: watches the mode, byte and result channels,
// predicts the result items of each accepted byte and compares them in order.
// Depends on wsws_pkg for the mode, kind and byte codes and the item type.
module wsws_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [wsws_pkg::ModeWidth-1:0] cfg_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [wsws_pkg::CharWidth-1:0] s_in_char,
    input  logic                           s_end_of_text,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [wsws_pkg::CharWidth-1:0] m_out_char,
    input  logic [wsws_pkg::KindWidth-1:0] m_item_kind,
    input  logic                           m_starts_word,
    input  logic                           m_line_break,
    input  logic                           m_last_of_run,
    output int                             mismatch_count,
    output int                             pending_results,
    output int                             results_seen
);
    import wsws_pkg::*;

    logic [ModeWidth-1:0] mode_q;
    bit                   text_start;
    bit                   after_space;
    bit                   after_newline;
    bit                   space_owed;
    item_t                expected_items[$];

    function automatic item_t word_item(input logic [CharWidth-1:0] ch,
                                        input logic [KindWidth-1:0] kind,
                                        input bit start, input bit brk);
        item_t it;
        it.out_char    = ch;
        it.item_kind   = kind;
        it.starts_word = start;
        it.line_break  = brk;
        it.last_of_run = 1'b0;
        return it;
    endfunction

    task automatic split_byte(input logic [CharWidth-1:0] ch, input logic eot);
        logic [ModeWidth-1:0] mode;
        bit                   ws;
        bit                   nl;
        item_t                made[2];
        int                   n;
        mode = mode_q;
        n    = 0;
        ws   = (ch == BYTE_SPACE) || (ch >= BYTE_TAB && ch <= BYTE_CR);
        nl   = (ch == BYTE_NEWLINE);
        if (mode > MODE_PRE_WRAP) begin
            mode = MODE_NORMAL;
        end
        if (mode != MODE_PRE_LINE) begin
            space_owed = 1'b0;
        end
        case (mode)
            MODE_PRE: begin
                made[n] = word_item(ch, KIND_CHAR, text_start || after_newline, nl);
                n++;
            end
            MODE_PRE_LINE: begin
                if (ws && nl) begin
                    space_owed = 1'b0;
                    made[n] = word_item(BYTE_NUL, KIND_BREAK, 1'b1, 1'b1);
                    n++;
                end else if (ws) begin
                    space_owed = 1'b1;
                end else begin
                    if (space_owed) begin
                        made[n] = word_item(BYTE_SPACE, KIND_SPACE, 1'b1, 1'b0);
                        n++;
                    end
                    space_owed = 1'b0;
                    made[n] = word_item(ch, KIND_CHAR, text_start || after_space, 1'b0);
                    n++;
                end
                if (eot && space_owed) begin
                    space_owed = 1'b0;
                    made[n] = word_item(BYTE_SPACE, KIND_SPACE, 1'b1, 1'b0);
                    n++;
                end
            end
            MODE_PRE_WRAP: begin
                made[n] = word_item(ch, KIND_CHAR, text_start || (ws != after_space), 1'b0);
                n++;
            end
            default: begin
                if (!ws) begin
                    made[n] = word_item(ch, KIND_CHAR, text_start || after_space, 1'b0);
                    n++;
                end else if (text_start || !after_space) begin
                    made[n] = word_item(BYTE_SPACE, KIND_SPACE, 1'b1, 1'b0);
                    n++;
                end
            end
        endcase
        if (n > 0) begin
            made[n-1].last_of_run = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            expected_items.insert(expected_items.size(), made[i]);
        end
        after_space   = ws;
        after_newline = nl;
        text_start    = 1'b0;
        if (eot) begin
            text_start    = 1'b1;
            after_space   = 1'b0;
            after_newline = 1'b0;
            space_owed    = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        item_t seen;
        item_t want;
        if (!aresetn) begin
            mode_q          = MODE_NORMAL;
            text_start      = 1'b1;
            after_space     = 1'b0;
            after_newline   = 1'b0;
            space_owed      = 1'b0;
            mismatch_count  = 0;
            results_seen    = 0;
            expected_items.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_q = cfg_data;
            end
            if (s_valid && s_ready) begin
                split_byte(s_in_char, s_end_of_text);
            end
            if (m_valid && m_ready) begin
                seen = {m_out_char, m_item_kind, m_starts_word, m_line_break, m_last_of_run};
                results_seen++;
                if (expected_items.size() == 0) begin
                    mismatch_count++;
                    $display({"%0t: unexpected result, expected none, ",
                              "got char %02h kind %0d start %0b break %0b last %0b"},
                             $time, seen.out_char, seen.item_kind, seen.starts_word,
                             seen.line_break, seen.last_of_run);
                end else begin
                    want = expected_items.pop_front();
                    if (seen !== want) begin
                        mismatch_count++;
                        $display({"%0t: result mismatch, expected char %02h kind %0d ",
                                  "start %0b break %0b last %0b"},
                                 $time, want.out_char, want.item_kind, want.starts_word,
                                 want.line_break, want.last_of_run);
                        $display({"%0t:                  got      char %02h kind %0d ",
                                  "start %0b break %0b last %0b"},
                                 $time, seen.out_char, seen.item_kind, seen.starts_word,
                                 seen.line_break, seen.last_of_run);
                    end
                end
            end
        end
        pending_results = expected_items.size();
    end

endmodule

[tb/sv/tb_whitespace_mode_word_splitter_top.sv]
`timescale 1ns / 1ps
// Testbench top for the white-space word splitter: clock, reset, mode writes and text stimulus.
// Depends on wsws_pkg, whitespace_mode_word_splitter_top and the wsws_checker module.
module tb_whitespace_mode_word_splitter_top;
    import wsws_pkg::*;

    localparam logic [ModeWidth-1:0] MODE_RESERVED = 3'd7;
    localparam int TOTAL_BYTES = 1950;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [ModeWidth-1:0] cfg_data      = MODE_NORMAL;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [CharWidth-1:0] s_in_char     = BYTE_NUL;
    logic                 s_end_of_text = 1'b0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [CharWidth-1:0] m_out_char;
    logic [KindWidth-1:0] m_item_kind;
    logic                 m_starts_word;
    logic                 m_line_break;
    logic                 m_last_of_run;

    int mismatch_count;
    int pending_results;
    int results_seen;
    int bytes_sent    = 0;
    int texts_done    = 0;
    int mode_writes   = 0;
    int burst_left    = 0;
    bit bursty        = 1'b0;
    int hold_requests = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    whitespace_mode_word_splitter_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_char     (s_in_char),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_item_kind   (m_item_kind),
        .m_starts_word (m_starts_word),
        .m_line_break  (m_line_break),
        .m_last_of_run (m_last_of_run)
    );

    wsws_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_char       (s_in_char),
        .s_end_of_text   (s_end_of_text),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_char      (m_out_char),
        .m_item_kind     (m_item_kind),
        .m_starts_word   (m_starts_word),
        .m_line_break    (m_line_break),
        .m_last_of_run   (m_last_of_run),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_seen    (results_seen)
    );

    function automatic logic [CharWidth-1:0] text_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 8'($urandom_range(8'h61, 8'h7a));
            4, 5:       return BYTE_SPACE;
            6:          return BYTE_NEWLINE;
            7:          return 8'($urandom_range(BYTE_TAB, BYTE_CR));
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic offer_byte(input logic [CharWidth-1:0] ch, input logic eot);
        int gap;
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_in_char     <= ch;
        s_end_of_text <= eot;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        if (eot) begin
            texts_done++;
        end
        if (bursty) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 10);
                repeat (gap) begin
                    @(negedge aclk);
                    s_valid <= 1'b0;
                end
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Stops the sender and waits until every predicted result has come out, then waits on
    // so that a byte that gives no result can leave the pipeline.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_mode(input logic [ModeWidth-1:0] mode);
        drain();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        mode_writes++;
    endtask

    initial begin
        int style;
        int stretch;
        int period;
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        forever begin
            style   = $urandom_range(0, 3);
            stretch = $urandom_range(20, 200);
            period  = $urandom_range(2, 8);
            for (int tick = 0; tick < stretch; tick++) begin
                @(negedge aclk);
                if (hold_requests != holds_served) begin
                    holds_served = hold_requests;
                    hold_left    = 400;
                end
                if (hold_left > 0) begin
                    hold_left--;
                    m_ready <= 1'b0;
                end else begin
                    case (style)
                        0:       m_ready <= 1'b1;
                        1:       m_ready <= 1'($urandom_range(0, 1));
                        2:       m_ready <= ($urandom_range(0, 3) != 0);
                        default: m_ready <= ((tick % period) != 0);
                    endcase
                end
            end
        end
    end

    initial begin
        int phase;
        int budget;
        int len;
        int k;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Normal mode from reset: NUL and 0xFF bytes, a mixed whitespace run.
        offer_byte(BYTE_NUL, 1'b0);
        offer_byte(8'hff, 1'b0);
        offer_byte(BYTE_SPACE, 1'b0);
        offer_byte(BYTE_TAB, 1'b0);
        offer_byte(BYTE_CR, 1'b0);
        offer_byte("x", 1'b1);

        // Pre-line: spaces dropped before a newline, a space after the last newline,
        // and a text that ends on a pending space.
        write_mode(MODE_PRE_LINE);
        offer_byte(BYTE_SPACE, 1'b0);
        offer_byte(BYTE_SPACE, 1'b0);
        offer_byte(BYTE_NEWLINE, 1'b0);
        offer_byte(BYTE_SPACE, 1'b0);
        offer_byte("a", 1'b0);
        offer_byte(BYTE_SPACE, 1'b1);

        // A pending pre-line space is dropped when the mode changes within a text.
        offer_byte(BYTE_SPACE, 1'b0);
        offer_byte(BYTE_SPACE, 1'b0);
        write_mode(MODE_PRE);
        offer_byte("b", 1'b0);
        offer_byte(BYTE_NEWLINE, 1'b0);
        offer_byte("c", 1'b1);

        write_mode(MODE_PRE_WRAP);
        offer_byte(BYTE_SPACE, 1'b0);
        offer_byte("d", 1'b0);
        offer_byte(BYTE_NEWLINE, 1'b0);
        offer_byte(BYTE_NEWLINE, 1'b1);

        write_mode(MODE_RESERVED);
        offer_byte(BYTE_SPACE, 1'b0);
        offer_byte("e", 1'b1);

        write_mode(MODE_NOWRAP);
        offer_byte("f", 1'b0);
        offer_byte(BYTE_SPACE, 1'b1);

        phase = 0;
        while (bytes_sent < TOTAL_BYTES) begin
            write_mode((phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7)));
            bursty     = (phase % 3) != 0;
            burst_left = 0;
            if (phase == 2 || phase == 9) begin
                hold_requests++;
            end
            budget = $urandom_range(100, 200);
            k = 0;
            while (k < budget) begin
                len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 40);
                for (int j = 0; j < len && k < budget; j++) begin
                    offer_byte(text_char(), j == len - 1);
                    k++;
                end
            end
            phase++;
        end

        drain();
        repeat (8) @(negedge aclk);
        $display({"Sent %0d bytes in %0d complete texts over %0d mode writes ",
                  "(all eight mode codes)."},
                 bytes_sent, texts_done, mode_writes);
        $display("Checked %0d result items against the prediction, %0d mismatches.",
                 results_seen, mismatch_count);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Run timed out with %0d results outstanding.", pending_results);
        $display("status: fail");
        $finish;
    end

endmodule
